// ===== hdl/cre_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the record envelope codec.
// No dependencies; cre_cfg_if and every codec module import this package.
`default_nettype none

package cre_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int LEN_W       = 9;
  localparam int POS_W       = 9;
  localparam int HDR_BYTES   = 12;
  localparam int CRC_BYTES   = 4;
  localparam int STEP_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // check-mode byte counter stops here
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PAYLOAD + HDR_BYTES + CRC_BYTES + 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [7:0] MAGIC [4] = '{8'h4E, 8'h50, 8'h52, 8'h52};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = CFG_IDX_W'(1);

  // back-end step codes within a built envelope
  localparam logic [STEP_W-1:0] STEP_PAYLOAD  = STEP_W'(HDR_BYTES);
  localparam logic [STEP_W-1:0] STEP_CRC0     = STEP_W'(HDR_BYTES + 1);
  localparam logic [STEP_W-1:0] STEP_CRC_LAST = STEP_W'(HDR_BYTES + CRC_BYTES);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_WRONG_SIZE   = 3'd1,
    ST_BAD_MAGIC    = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_CRC_MISMATCH = 3'd4
  } status_t;

  // one unit of work handed from the front end to the back end
  typedef struct packed {
    logic             verdict;  // 1: check verdict, 0: build payload byte
    logic             first;    // build: header goes out ahead of this byte
    logic             closes;   // build: CRC trailer goes out after this byte
    logic [7:0]       data;
    logic [31:0]      gen;
    logic [LEN_W-1:0] len;
    status_t          status;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    if (l == '0) begin
      return LEN_W'(1);
    end else if (l > LEN_W'(MAX_PAYLOAD)) begin
      return LEN_W'(MAX_PAYLOAD);
    end
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cre_in_if.sv =====
// Input item channel of the record envelope codec.
// Depends on nothing.
`default_nettype none

interface cre_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [31:0] generation_in;

  modport source (output valid, in_byte, in_last, generation_in, input ready);
  modport sink   (input valid, in_byte, in_last, generation_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/cre_out_if.sv =====
// Result item channel of the record envelope codec.
// Depends on nothing.
`default_nettype none

interface cre_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        is_verdict;
  logic        envelope_ok;
  logic [2:0]  status;
  logic [31:0] generation;

  modport source (output valid, out_byte, out_last, is_verdict, envelope_ok, status,
                  generation, input ready);
  modport sink   (input valid, out_byte, out_last, is_verdict, envelope_ok, status,
                  generation, output ready);
endinterface

`default_nettype wire

// ===== hdl/cre_cfg_if.sv =====
// Configuration write channel of the record envelope codec.
// Depends on cre_pkg for widths.
`default_nettype none

interface cre_cfg_if;
  import cre_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/crc32_record_envelope_codec.sv =====
// CRC-32 framed record codec. In check mode (mode = 0) one envelope byte is taken per cycle
// and a single verdict item comes out for the byte marked last: ok with the generation, or
// wrong size, bad magic, length-field mismatch, CRC mismatch, checked in that order. In build
// mode (mode = 1) payload bytes go in and envelope bytes come out: the 12-byte header ahead
// of the first payload byte and the four reflected CRC-32 bytes after payload_length bytes.
// Rate: check mode sustains one item per cycle while the job queue has room. Build mode is
// bound by the output side, one envelope byte per cycle from the back end's byte-wide CRC
// update while the sink is ready; first and closing bytes also carry the header and trailer.
// A two-entry job queue separates the front end (register file, envelope tracking, check-mode
// CRC) from the back end (byte expansion, output register), so input keeps flowing while a
// result waits. Change configuration only with no results pending; a mode write drops any
// partial envelope. No clearing pass after reset.
// Depends on cre_pkg, the three channel interfaces, cre_front, cre_queue, cre_back.
`default_nettype none

module crc32_record_envelope_codec import cre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cre_in_if.sink    in_ch,
  cre_out_if.source out_ch,
  cre_cfg_if.sink   cfg_ch
);

  logic q_full, q_empty, push, pop;
  job_t push_job, head;

  // front: classifies each item into at most one job
  cre_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  cre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // back: one result item per cycle from the head job while the output side is ready
  cre_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== hdl/cre_front.sv =====
// Front end: config registers, envelope tracking, check-mode CRC and verdicts.
// Depends on cre_pkg, cre_in_if, cre_cfg_if.
`default_nettype none

module cre_front import cre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cre_in_if.sink     in_ch,
  cre_cfg_if.sink    cfg_ch,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic             mode_r;
  logic [LEN_W-1:0] plen_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      body_crc_r, body_crc_nxt;
  logic [31:0]      trailer_r, trailer_nxt;
  logic [31:0]      gen_r, gen_nxt;
  logic [31:0]      lenw_r, lenw_nxt;
  logic             magic_good_r, magic_good_nxt;

  logic             fire, cfg_fire, clear;
  logic [LEN_W-1:0] len;
  logic [POS_W-1:0] body, toff;
  logic [4:0]       lane_sh;
  logic [31:0]      b_w;
  status_t          st;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign fire         = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign len     = eff_len(plen_r);
  assign body    = POS_W'(HDR_BYTES) + POS_W'(len);
  assign toff    = pos_r - body;
  assign lane_sh = {pos_r[1:0], 3'b000};
  assign b_w     = {24'b0, in_ch.in_byte};

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    body_crc_nxt   = body_crc_r;
    trailer_nxt    = trailer_r;
    gen_nxt        = gen_r;
    lenw_nxt       = lenw_r;
    magic_good_nxt = magic_good_r;
    clear          = 1'b0;
    st             = ST_OK;
    push           = 1'b0;
    push_job       = '0;

    if (mode_r) begin
      // build: count payload bytes, close at the configured count, clamped to 1..MAX_PAYLOAD
      push_job.verdict = 1'b0;
      push_job.first   = (pos_r == '0);
      push_job.closes  = ((pos_r + POS_W'(1)) >= POS_W'(len));
      push_job.data    = in_ch.in_byte;
      push_job.gen     = in_ch.generation_in;
      push_job.len     = len;
      push             = fire;
      pos_nxt          = push_job.closes ? '0 : pos_r + POS_W'(1);
    end else begin
      if (pos_r < POS_W'(4)) begin
        if (in_ch.in_byte != MAGIC[pos_r[1:0]]) magic_good_nxt = 1'b0;
      end else if (pos_r < POS_W'(8)) begin
        gen_nxt = gen_r | (b_w << lane_sh);
      end else if (pos_r < POS_W'(HDR_BYTES)) begin
        lenw_nxt = lenw_r | (b_w << lane_sh);
      end
      if (pos_r < body) begin
        crc_nxt = crc_byte(crc_r, in_ch.in_byte);
        if (pos_r == body - POS_W'(1)) body_crc_nxt = ~crc_nxt;
      end else if (pos_r < body + POS_W'(CRC_BYTES)) begin
        trailer_nxt = trailer_r | (b_w << {toff[1:0], 3'b000});
      end
      if (pos_r < POS_SAT) pos_nxt = pos_r + POS_W'(1);

      // verdict checks in priority order
      if ((pos_r + POS_W'(1)) != body + POS_W'(CRC_BYTES)) st = ST_WRONG_SIZE;
      else if (!magic_good_nxt)                           st = ST_BAD_MAGIC;
      else if (lenw_nxt != {{(32-LEN_W){1'b0}}, len})     st = ST_LEN_MISMATCH;
      else if (body_crc_nxt != trailer_nxt)               st = ST_CRC_MISMATCH;
      else                                                st = ST_OK;

      push_job.verdict = 1'b1;
      push_job.status  = st;
      push_job.gen     = (st == ST_OK) ? gen_nxt : 32'b0;
      push             = fire && in_ch.in_last;
      clear            = in_ch.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      plen_r       <= LEN_W'(1);
      pos_r        <= '0;
      crc_r        <= CRC_ONES;
      body_crc_r   <= '0;
      trailer_r    <= '0;
      gen_r        <= '0;
      lenw_r       <= '0;
      magic_good_r <= 1'b1;
    end else if (cfg_fire && cfg_ch.index == REG_MODE) begin
      // a mode write drops any partial envelope
      mode_r       <= cfg_ch.data[0];
      pos_r        <= '0;
      crc_r        <= CRC_ONES;
      body_crc_r   <= '0;
      trailer_r    <= '0;
      gen_r        <= '0;
      lenw_r       <= '0;
      magic_good_r <= 1'b1;
    end else if (cfg_fire && cfg_ch.index == REG_PAYLOAD_LEN) begin
      plen_r <= cfg_ch.data[LEN_W-1:0];
    end else if (fire) begin
      if (clear) begin
        pos_r        <= '0;
        crc_r        <= CRC_ONES;
        body_crc_r   <= '0;
        trailer_r    <= '0;
        gen_r        <= '0;
        lenw_r       <= '0;
        magic_good_r <= 1'b1;
      end else begin
        pos_r        <= pos_nxt;
        crc_r        <= crc_nxt;
        body_crc_r   <= body_crc_nxt;
        trailer_r    <= trailer_nxt;
        gen_r        <= gen_nxt;
        lenw_r       <= lenw_nxt;
        magic_good_r <= magic_good_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cre_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on cre_pkg.
`default_nettype none

module cre_queue import cre_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== hdl/cre_back.sv =====
// Back end: expands jobs into result items, builds header and CRC trailer.
// Depends on cre_pkg, cre_out_if.
`default_nettype none

module cre_back import cre_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    empty,
  input  job_t    head,
  output logic    pop,
  cre_out_if.source out_ch
);

  logic [STEP_W-1:0] step_r, eff;
  logic [31:0]       crc_r, crc_cur, lenw, fin;
  logic [7:0]        byte_sel;
  logic              adv, done, last_sel;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r, is_verdict_r, ok_r;
  status_t           status_r;
  logic [31:0]       gen_out_r;

  assign adv  = !empty && (!out_valid_r || out_ch.ready);
  // a non-first payload job starts at the payload step
  assign eff  = head.first ? step_r : step_r + STEP_PAYLOAD;
  assign lenw = {{(32-LEN_W){1'b0}}, head.len};
  assign fin  = ~crc_r;
  assign crc_cur  = (eff == '0) ? CRC_ONES : crc_r;
  assign done     = head.verdict || (eff == (head.closes ? STEP_CRC_LAST : STEP_PAYLOAD));
  assign last_sel = !head.verdict && (eff == STEP_CRC_LAST);
  assign pop      = adv && done;

  always_comb begin
    logic [STEP_W-1:0] coff;
    coff = eff - STEP_CRC0;
    if (eff < STEP_W'(4))             byte_sel = MAGIC[eff[1:0]];
    else if (eff < STEP_W'(8))        byte_sel = head.gen[{eff[1:0], 3'b000} +: 8];
    else if (eff < STEP_PAYLOAD)      byte_sel = lenw[{eff[1:0], 3'b000} +: 8];
    else if (eff == STEP_PAYLOAD)     byte_sel = head.data;
    else                              byte_sel = fin[{coff[1:0], 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      step_r      <= done ? '0 : step_r + STEP_W'(1);
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (head.verdict) begin
        out_byte_r   <= 8'b0;
        out_last_r   <= 1'b0;
        is_verdict_r <= 1'b1;
        ok_r         <= (head.status == ST_OK);
        status_r     <= head.status;
        gen_out_r    <= head.gen;
      end else begin
        out_byte_r   <= byte_sel;
        out_last_r   <= last_sel;
        is_verdict_r <= 1'b0;
        ok_r         <= 1'b0;
        status_r     <= ST_OK;
        gen_out_r    <= 32'b0;
        if (eff <= STEP_PAYLOAD) crc_r <= crc_byte(crc_cur, byte_sel);
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.out_last    = out_last_r;
  assign out_ch.is_verdict  = is_verdict_r;
  assign out_ch.envelope_ok = ok_r;
  assign out_ch.status      = status_r;
  assign out_ch.generation  = gen_out_r;

  a_last_not_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> !is_verdict_r) else $error("last flag on a verdict");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && is_verdict_r |-> (ok_r == (status_r == ST_OK)))
    else $error("verdict ok flag disagrees with status");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (eff <= STEP_CRC_LAST)) else $error("build step out of range");

endmodule

`default_nettype wire
